// ===== design/sms_pkg.sv =====
// Shared constants, register codes and a byte helper for the substring match stream.
package sms_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 16;
  localparam int TYPE_COUNT    = 32;

  localparam int BYTE_BITS     = 8;
  localparam int RECORD_BITS   = 16;
  localparam int KIND_BITS     = 5;
  localparam int OFFSET_BITS   = 16;

  localparam int PATTERN_WORD_BITS = 64;
  localparam int PATTERN_LEN_BITS  = 5;
  localparam int TYPE_MASK_BITS    = 32;

  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_MATCH_CASE     = 3'd3,
    REG_TYPE_MASK      = 3'd4
  } reg_index_t;

  // ASCII A-Z to a-z unless exact compare is selected
  function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] b,
                                                     input logic exact);
    logic [BYTE_BITS-1:0] r;
    r = b;
    if (!exact && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== design/sms_in_if.sv =====
// Text item channel: one byte of key or value text with its record tags.
interface sms_in_if;
  logic                             valid;
  logic                             ready;
  logic [sms_pkg::BYTE_BITS-1:0]    text_byte;
  logic                             field_last;
  logic                             field_is_key;
  logic [sms_pkg::RECORD_BITS-1:0]  record_number;
  logic [sms_pkg::KIND_BITS-1:0]    record_kind;

  modport source (output valid, text_byte, field_last, field_is_key, record_number,
                  record_kind, input ready);
  modport sink (input valid, text_byte, field_last, field_is_key, record_number,
                record_kind, output ready);
endinterface

// ===== design/sms_out_if.sv =====
// Match item channel: location of one pattern occurrence.
interface sms_out_if;
  logic                             valid;
  logic                             ready;
  logic [sms_pkg::KIND_BITS-1:0]    hit_kind;
  logic [sms_pkg::RECORD_BITS-1:0]  hit_record;
  logic                             hit_in_key;
  logic [sms_pkg::OFFSET_BITS-1:0]  hit_start;
  logic [sms_pkg::OFFSET_BITS-1:0]  hit_end;

  modport source (output valid, hit_kind, hit_record, hit_in_key, hit_start, hit_end,
                  input ready);
  modport sink (input valid, hit_kind, hit_record, hit_in_key, hit_start, hit_end,
                output ready);
endinterface

// ===== design/sms_matcher.sv =====
// Parallel window compare against the pattern for every candidate length.
module sms_matcher #(
  parameter int MAX_PATTERN = sms_pkg::MAX_PATTERN,
  localparam int LenBits    = $clog2(MAX_PATTERN + 1)
) (
  input  logic [sms_pkg::BYTE_BITS-1:0]               window [MAX_PATTERN],
  input  logic [sms_pkg::BYTE_BITS*MAX_PATTERN-1:0]   pattern,
  input  logic [LenBits-1:0]                          len,
  input  logic                                        exact,
  output logic                                        hit
);

  logic [sms_pkg::BYTE_BITS-1:0] win_f [MAX_PATTERN];
  logic [sms_pkg::BYTE_BITS-1:0] pat_f [MAX_PATTERN];
  logic [MAX_PATTERN:0]          len_ok;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_f[i] = sms_pkg::fold_byte(window[i], exact);
      pat_f[i] = sms_pkg::fold_byte(pattern[i*sms_pkg::BYTE_BITS +: sms_pkg::BYTE_BITS],
                                    exact);
    end
  end

  // len_ok[L]: newest L bytes (oldest first) equal pattern bytes 0..L-1
  always_comb begin
    len_ok = '0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      len_ok[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (win_f[l-1-j] != pat_f[j]) begin
          len_ok[l] = 1'b0;
        end
      end
    end
  end

  assign hit = len_ok[len];

endmodule

// ===== design/substring_match_stream_top.sv =====
// Streaming substring search over record text with type filter and match offsets.
// Takes one text item per cycle unless a held result stalls it: an item is registered at the input,
// compared against the pattern over the whole byte window in one pass, and any match
// lands in the result register, which drives the output; a stall can hold the item
// in the input register before its match moves on to the result register.
// The input stays ready whenever the result register is empty or being
// taken; only a held result with a waiting item behind it stops the input. Config
// writes take effect on the next cycle and are meant for idle periods only.
module substring_match_stream_top #(
  parameter int MAX_PATTERN   = sms_pkg::MAX_PATTERN,
  parameter int POSITION_BITS = sms_pkg::POSITION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  sms_in_if.sink                               text_in,
  sms_out_if.source                            hit_out,
  input  logic                                 cfg_write,
  input  logic [sms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sms_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int LenBits = $clog2(MAX_PATTERN + 1);

  // config registers
  logic [sms_pkg::PATTERN_WORD_BITS-1:0] pat_low;
  logic [sms_pkg::PATTERN_WORD_BITS-1:0] pat_high;
  logic [sms_pkg::PATTERN_LEN_BITS-1:0]  pat_len;
  logic                                  match_case;
  logic [sms_pkg::TYPE_MASK_BITS-1:0]    type_mask;

  // input register
  logic                               s1_valid;
  logic [sms_pkg::BYTE_BITS-1:0]      s1_byte;
  logic                               s1_last;
  logic                               s1_key;
  logic [sms_pkg::RECORD_BITS-1:0]    s1_record;
  logic [sms_pkg::KIND_BITS-1:0]      s1_kind;

  // scan state
  logic [sms_pkg::BYTE_BITS-1:0]      window [MAX_PATTERN];
  logic [sms_pkg::BYTE_BITS-1:0]      window_next [MAX_PATTERN];
  logic [POSITION_BITS-1:0]           pos;
  logic [POSITION_BITS-1:0]           pos_inc;
  logic [LenBits-1:0]                 skip;
  logic [LenBits-1:0]                 len_eff;

  // result register
  logic                               out_valid;
  logic [sms_pkg::KIND_BITS-1:0]      out_kind;
  logic [sms_pkg::RECORD_BITS-1:0]    out_record;
  logic                               out_key;
  logic [sms_pkg::OFFSET_BITS-1:0]    out_start;
  logic [sms_pkg::OFFSET_BITS-1:0]    out_end;

  logic advance;
  logic accept;
  logic kind_ok;
  logic win_hit;
  logic hit;

  logic [2*sms_pkg::PATTERN_WORD_BITS-1:0] pat_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low    <= '0;
      pat_high   <= '0;
      pat_len    <= '0;
      match_case <= 1'b0;
      type_mask  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sms_pkg::REG_PATTERN_LOW:    pat_low    <= cfg_data;
        sms_pkg::REG_PATTERN_HIGH:   pat_high   <= cfg_data;
        sms_pkg::REG_PATTERN_LENGTH: pat_len    <= cfg_data[sms_pkg::PATTERN_LEN_BITS-1:0];
        sms_pkg::REG_MATCH_CASE:     match_case <= cfg_data[0];
        sms_pkg::REG_TYPE_MASK:      type_mask  <= cfg_data[sms_pkg::TYPE_MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = s1_valid && (!out_valid || hit_out.ready);
  assign text_in.ready = !s1_valid || advance;
  assign accept        = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte   <= text_in.text_byte;
      s1_last   <= text_in.field_last;
      s1_key    <= text_in.field_is_key;
      s1_record <= text_in.record_number;
      s1_kind   <= text_in.record_kind;
    end
  end

  always_comb begin
    if (type_mask == '0) begin
      kind_ok = 1'b1;
    end else if (32'(s1_kind) >= 32'(sms_pkg::TYPE_COUNT)) begin
      kind_ok = 1'b0;
    end else begin
      kind_ok = type_mask[s1_kind];
    end
  end

  always_comb begin
    if (32'(pat_len) > 32'(MAX_PATTERN)) begin
      len_eff = LenBits'(MAX_PATTERN);
    end else begin
      len_eff = LenBits'(pat_len);
    end
  end

  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign pos_inc = (pos == {POSITION_BITS{1'b1}}) ? pos : pos + 1'b1;
  assign pat_all = {pat_high, pat_low};

  sms_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .window  (window_next),
    .pattern (pat_all[sms_pkg::BYTE_BITS*MAX_PATTERN-1:0]),
    .len     (len_eff),
    .exact   (match_case),
    .hit     (win_hit)
  );

  assign hit = kind_ok && (skip == '0) && (len_eff != '0) &&
               (pos_inc >= POSITION_BITS'(len_eff)) && win_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      skip <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= '0;
      end
    end else if (advance) begin
      if (kind_ok) begin
        window <= window_next;
      end
      if (s1_last) begin
        pos  <= '0;
        skip <= '0;
      end else if (kind_ok) begin
        pos <= pos_inc;
        if (skip != '0) begin
          skip <= skip - 1'b1;
        end else if (hit) begin
          skip <= len_eff - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end else if (hit_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_kind   <= s1_kind;
      out_record <= s1_record;
      out_key    <= s1_key;
      out_start  <= sms_pkg::OFFSET_BITS'(pos_inc - POSITION_BITS'(len_eff));
      out_end    <= sms_pkg::OFFSET_BITS'(pos_inc);
    end
  end

  assign hit_out.valid      = out_valid;
  assign hit_out.hit_kind   = out_kind;
  assign hit_out.hit_record = out_record;
  assign hit_out.hit_in_key = out_key;
  assign hit_out.hit_start  = out_start;
  assign hit_out.hit_end    = out_end;

endmodule

// ===== design/sms_checker.sv =====
// Port-level checks for the substring match stream, bound to the top level.
module sms_checker #(
  parameter int MAX_PATTERN = sms_pkg::MAX_PATTERN
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sms_pkg::OFFSET_BITS-1:0]   hit_start,
  input logic [sms_pkg::OFFSET_BITS-1:0]   hit_end
);

  logic [sms_pkg::OFFSET_BITS-1:0] span;

  assign span = hit_end - hit_start;

  // a match spans between one byte and the longest pattern
  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (span != '0) && (span <= sms_pkg::OFFSET_BITS'(MAX_PATTERN)))
    else $error("match span out of range");

  // an empty result register never holds back the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a fresh result comes from an input item that passed through the input register without waiting
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

endmodule

bind substring_match_stream_top sms_checker #(
  .MAX_PATTERN (MAX_PATTERN)
) u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .out_valid (hit_out.valid),
  .out_ready (hit_out.ready),
  .hit_start (hit_out.hit_start),
  .hit_end   (hit_out.hit_end)
);
